// ===== design/ecal_pkg.sv =====
`timescale 1ns / 1ps
// ecal_pkg: types, constants and calendar helpers for the epoch-to-calendar block.
// No dependencies; used by epoch_seconds_to_calendar and its bench.
package ecal_pkg;

    localparam int unsigned EpochW   = 32;
    localparam int unsigned DaysW    = 17;   // whole days up to 49710, plus weekday offset
    localparam int unsigned RemW     = 17;   // remainder of the widest divide (< 86400)
    localparam int unsigned YearW    = 8;

    localparam logic [RemW-1:0] SecsPerDay  = 17'd86400;
    localparam logic [RemW-1:0] SecsPerHour = 17'd3600;
    localparam logic [RemW-1:0] SecsPerMin  = 17'd60;
    localparam logic [RemW-1:0] DaysPerWeek = 17'd7;
    localparam logic [DaysW-1:0] EpochWeekday = 17'd4;   // 1970-01-01 was a Thursday
    localparam logic [YearW-1:0] EpochYear   = 8'd70;    // 1970 - 1900
    localparam logic [DaysW-1:0] DaysLeap    = 17'd366;
    localparam logic [DaysW-1:0] DaysCommon  = 17'd365;
    localparam logic [3:0] LastMonth = 4'd11;

    // Reciprocals: x / d == (x * Recip) >> Sh, exact over the operand range used.
    localparam int unsigned MulW = 26;
    localparam logic [MulW-1:0] RecipDay  = 26'd50903317;  // 2^35 / 675, on seconds >> 7
    localparam int unsigned     ShDay     = 35;
    localparam logic [MulW-1:0] RecipHour = 26'd9321;      // 2^21 / 225, on seconds >> 4
    localparam int unsigned     ShHour    = 21;
    localparam logic [MulW-1:0] RecipMin  = 26'd1093;      // 2^14 / 15, on seconds >> 2
    localparam int unsigned     ShMin     = 14;
    localparam logic [MulW-1:0] RecipWeek = 26'd74899;     // 2^19 / 7, on days
    localparam int unsigned     ShWeek    = 19;

    typedef struct packed {
        logic [EpochW-1:0] epoch_seconds;
    } t_req;

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] month_day;
        logic [3:0] month;
        logic [7:0] years_since_1900;
        logic [2:0] weekday;
        logic [8:0] year_day;
    } t_rsp;

    // Years 1970..2106 only: y is the year minus 1900, so the low bits give
    // the divisible-by-4 test; 2000 is a leap year, 2100 is not.
    function automatic logic is_leap(input logic [YearW-1:0] y);
        return (y[1:0] == 2'd0) && (y != 8'd200);
    endfunction

    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd30;
            4'd5:    len = 5'd30;
            4'd8:    len = 5'd30;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== design/ecal_chan.sv =====
`timescale 1ns / 1ps
// ecal_chan: valid/ready channel carrying one payload of type T.
// No dependencies beyond the payload type handed in.
interface ecal_chan #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/epoch_seconds_to_calendar.sv =====
`timescale 1ns / 1ps
// epoch_seconds_to_calendar: unsigned Unix seconds to broken-down UTC date and time.
// Depends on ecal_pkg and ecal_chan.
//
// Usage
//   i_req carries one request: a 32-bit count of seconds since 1970-01-01 UTC.
//   o_rsp returns second, minute, hour, day of month, month, years since 1900,
//   weekday (0 = Sunday) and 0-based day of year, one response per request.
//   i_req.ready is high only while the converter is idle; one request is
//   worked on at a time.
//   The work runs as a sequence on the shared multiplier and subtractor:
//   reciprocal multiply, back-multiply and subtract (three steps each for
//   days, hours, minutes and the weekday), a walk over the years from 1970,
//   a walk over the months, and a load of the output register. The
//   converter is idle again once the output register loads.
//   The result sits in an output register; a new request is taken while it
//   waits. If the receiver stalls, the next result holds in its final state
//   until the register frees, and no new request is taken meanwhile.
//   Reset clears the sequencer and the output valid; no clearing pass.
module epoch_seconds_to_calendar (
    input  logic i_clk,
    input  logic i_rst_n,
    ecal_chan.sink   i_req,
    ecal_chan.source o_rsp
);
    import ecal_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_YEAR  = 3'd2;
    localparam logic [2:0] S_MONTH = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // each unit: Q forms the quotient, P the quotient times the divisor, R the remainder
    localparam logic [3:0] P_DAY_Q  = 4'd0;
    localparam logic [3:0] P_DAY_P  = 4'd1;
    localparam logic [3:0] P_DAY_R  = 4'd2;
    localparam logic [3:0] P_HOUR_Q = 4'd3;
    localparam logic [3:0] P_HOUR_P = 4'd4;
    localparam logic [3:0] P_HOUR_R = 4'd5;
    localparam logic [3:0] P_MIN_Q  = 4'd6;
    localparam logic [3:0] P_MIN_P  = 4'd7;
    localparam logic [3:0] P_MIN_R  = 4'd8;
    localparam logic [3:0] P_WDAY_Q = 4'd9;
    localparam logic [3:0] P_WDAY_P = 4'd10;
    localparam logic [3:0] P_WDAY_R = 4'd11;

    logic [2:0]        r_state;
    logic [3:0]        r_phase;
    logic [RemW-1:0]   r_rem;
    logic [EpochW-1:0] r_secs;
    logic [2*MulW-1:0] r_prod;
    logic [DaysW-1:0]  r_days;
    logic [DaysW-1:0]  r_wday_in;
    logic [5:0]        r_sec;
    logic [5:0]        r_min;
    logic [4:0]        r_hour;
    logic [2:0]        r_wday;
    logic [YearW-1:0]  r_year;
    logic [8:0]        r_yday;
    logic [3:0]        r_month;
    logic              r_ovalid;
    t_rsp              r_out;

    // shared subtractor and multiplier
    logic [RemW:0]   a_op;
    logic [RemW:0]   b_op;
    logic [RemW+1:0] diff;
    logic            borrow;
    logic [MulW-1:0]   mul_a;
    logic [MulW-1:0]   mul_b;
    logic [2*MulW-1:0] n_prod;
    logic [DaysW-1:0]  day_q;
    logic [4:0]        hour_q;
    logic [5:0]        min_q;
    logic [DaysW-1:0]  week_q;
    logic            leap;
    logic [4:0]      mlen;
    logic            out_load;

    assign day_q  = r_prod[ShDay +: DaysW];
    assign hour_q = r_prod[ShHour +: 5];
    assign min_q  = r_prod[ShMin +: 6];
    assign week_q = r_prod[ShWeek +: DaysW];

    always_comb begin
        case (r_phase)
            P_DAY_Q:  begin mul_a = MulW'(r_secs[EpochW-1:7]); mul_b = RecipDay;  end
            P_DAY_P:  begin mul_a = MulW'(day_q);  mul_b = MulW'(SecsPerDay);     end
            P_HOUR_Q: begin mul_a = MulW'(r_rem[RemW-1:4]);   mul_b = RecipHour; end
            P_HOUR_P: begin mul_a = MulW'(hour_q); mul_b = MulW'(SecsPerHour);    end
            P_MIN_Q:  begin mul_a = MulW'(r_rem[11:2]);       mul_b = RecipMin;  end
            P_MIN_P:  begin mul_a = MulW'(min_q);  mul_b = MulW'(SecsPerMin);     end
            P_WDAY_Q: begin mul_a = MulW'(r_wday_in);         mul_b = RecipWeek; end
            P_WDAY_P: begin mul_a = MulW'(week_q); mul_b = MulW'(DaysPerWeek);    end
            default:  begin mul_a = '0;            mul_b = '0;                    end
        endcase
    end

    assign n_prod = {{MulW{1'b0}}, mul_a} * {{MulW{1'b0}}, mul_b};

    assign leap = is_leap(r_year);
    assign mlen = month_len(leap, r_month);

    always_comb begin
        case (r_state)
            S_DIV: begin
                // remainders fit in RemW bits, so the low bits of the product suffice
                case (r_phase)
                    P_DAY_R:  a_op = {1'b0, r_secs[RemW-1:0]};
                    P_WDAY_R: a_op = {1'b0, r_wday_in};
                    default:  a_op = {1'b0, r_rem};
                endcase
                b_op = {1'b0, r_prod[RemW-1:0]};
            end
            S_YEAR: begin
                a_op = {1'b0, r_days};
                b_op = {1'b0, (leap ? DaysLeap : DaysCommon)};
            end
            default: begin
                a_op = {1'b0, r_days};
                b_op = {{(RemW-4){1'b0}}, mlen};
            end
        endcase
    end

    assign diff   = {1'b0, a_op} - {1'b0, b_op};
    assign borrow = diff[RemW+1];

    assign out_load = (r_state == S_DONE) && (!r_ovalid || o_rsp.ready);

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= P_DAY_Q;
            r_ovalid <= 1'b0;
        end else begin
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_secs  <= i_req.data.epoch_seconds;
                        r_phase <= P_DAY_Q;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_prod  <= n_prod;
                    r_phase <= (r_phase == P_WDAY_R) ? P_DAY_Q : r_phase + 4'd1;
                    case (r_phase)
                        P_DAY_P: begin
                            r_days    <= day_q;
                            r_wday_in <= day_q + EpochWeekday;
                        end
                        P_DAY_R, P_HOUR_R: begin
                            r_rem <= diff[RemW-1:0];
                        end
                        P_HOUR_P: begin
                            r_hour <= hour_q;
                        end
                        P_MIN_P: begin
                            r_min <= min_q;
                        end
                        P_MIN_R: begin
                            r_sec <= diff[5:0];
                        end
                        P_WDAY_R: begin
                            r_wday  <= diff[2:0];
                            r_year  <= EpochYear;
                            r_state <= S_YEAR;
                        end
                        default: begin
                        end
                    endcase
                end
                S_YEAR: begin
                    if (borrow) begin
                        r_yday  <= r_days[8:0];
                        r_month <= 4'd0;
                        r_state <= S_MONTH;
                    end else begin
                        r_days <= diff[DaysW-1:0];
                        r_year <= r_year + 8'd1;
                    end
                end
                S_MONTH: begin
                    if (borrow || r_month == LastMonth) begin
                        r_state <= S_DONE;
                    end else begin
                        r_days  <= diff[DaysW-1:0];
                        r_month <= r_month + 4'd1;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out.second           <= r_sec;
                        r_out.minute           <= r_min;
                        r_out.hour             <= r_hour;
                        r_out.month_day        <= r_days[4:0] + 5'd1;
                        r_out.month            <= r_month;
                        r_out.years_since_1900 <= r_year;
                        r_out.weekday          <= r_wday;
                        r_out.year_day         <= r_yday;
                        r_state                <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for epoch_seconds_to_calendar, which turns Unix seconds into a UTC date.
// Depends on ecal_pkg, ecal_chan and the block; an internal calendar predictor checks each response.
module tb;
    import ecal_pkg::*;

    localparam int unsigned CycleLimit   = 3_000_000;
    localparam int unsigned DrainCycles  = 300;
    localparam int unsigned PhaseItems   = 245;
    localparam int unsigned NumPhases    = 8;
    localparam int unsigned LastEpochDay = 49710;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ecal_chan #(.T(t_req)) req_ch ();
    ecal_chan #(.T(t_rsp)) rsp_ch ();

    epoch_seconds_to_calendar u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    logic [31:0]  pending_epochs[$];
    t_rsp         expected_dates[$];
    int unsigned  error_count   = 0;
    int unsigned  cycle_count   = 0;
    int unsigned  send_idle_pct = 0;
    int unsigned  stall_pct     = 0;
    logic         req_fire      = 1'b0;

    // ---------------------------------------------------------------- predictor
    function automatic bit gregorian_leap(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned year_start_day(input int unsigned y);
        int unsigned d;
        d = 0;
        for (int unsigned yy = 1970; yy < y; yy++) begin
            d += gregorian_leap(yy) ? 366 : 365;
        end
        return d;
    endfunction

    function automatic t_rsp calendar_from_epoch(input logic [31:0] secs);
        int unsigned rest, days, year, mon, ylen;
        int unsigned mlen[12];
        t_rsp r;
        mlen = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        r.second = 6'(secs % 60);
        rest     = secs / 60;
        r.minute = 6'(rest % 60);
        rest     = rest / 60;
        r.hour   = 5'(rest % 24);
        days     = rest / 24;
        r.weekday = 3'((days + 4) % 7);   // day zero was a Thursday
        year = 1970;
        ylen = 365;
        forever begin
            ylen = gregorian_leap(year) ? 366 : 365;
            if (days < ylen) break;
            days -= ylen;
            year++;
        end
        r.year_day = 9'(days);
        if (gregorian_leap(year)) mlen[1] = 29;
        mon = 0;
        while (mon < 11 && days >= mlen[mon]) begin
            days -= mlen[mon];
            mon++;
        end
        r.month_day        = 5'(days + 1);
        r.month            = 4'(mon);
        r.years_since_1900 = 8'(year - 1900);
        return r;
    endfunction

    // ------------------------------------------------------------- stimulus
    function automatic logic [31:0] random_epoch();
        longint unsigned s;
        int unsigned y, d;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: begin
                // land near a year, leap-day or month edge
                y = $urandom_range(1970, 2106);
                d = year_start_day(y);
                case ($urandom_range(0, 4))
                    0: d = d;
                    1: d = d + $urandom_range(58, 60);
                    2: d = d + (gregorian_leap(y) ? 365 : 364);
                    3: d = (d > 0) ? d - 1 : d;
                    default: d = d + $urandom_range(0, 365);
                endcase
                if (d > LastEpochDay) d = LastEpochDay;
                s = longint'(d) * 86400;
                case ($urandom_range(0, 2))
                    0: s = s;
                    1: s = s + 86399;
                    default: s = s + $urandom_range(0, 86399);
                endcase
                if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF - $urandom_range(0, 86399);
                return 32'(s);
            end
            2: return $urandom_range(0, 200000);
            default: return 32'hFFF0_0000 | 32'($urandom_range(0, 20'hFFFFF));
        endcase
    endfunction

    // ------------------------------------------------------------- checking
    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    task automatic compare_field(input string name, input int unsigned got,
                                 input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // ---------------------------------------------------------------- driver
    always @(negedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_fire) begin
            if (pending_epochs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                req_ch.data  <= '{epoch_seconds: pending_epochs.pop_front()};
                req_ch.valid <= 1'b1;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // --------------------------------------------------------------- monitor
    always @(posedge i_clk) begin : monitor
        t_rsp want, got;
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("FAIL");
            $finish;
        end else begin
            req_fire <= i_rst_n && req_ch.valid && req_ch.ready;
            if (i_rst_n && req_ch.valid && req_ch.ready)
                expected_dates.push_back(calendar_from_epoch(req_ch.data.epoch_seconds));
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
                got = rsp_ch.data;
                if (expected_dates.size() == 0) begin
                    report_mismatch("response with no request outstanding");
                end else begin
                    want = expected_dates.pop_front();
                    compare_field("second", got.second, want.second);
                    compare_field("minute", got.minute, want.minute);
                    compare_field("hour", got.hour, want.hour);
                    compare_field("month_day", got.month_day, want.month_day);
                    compare_field("month", got.month, want.month);
                    compare_field("years_since_1900", got.years_since_1900,
                                  want.years_since_1900);
                    compare_field("weekday", got.weekday, want.weekday);
                    compare_field("year_day", got.year_day, want.year_day);
                end
            end
        end
    end

    // -------------------------------------------------------------- sequence
    initial begin
        i_rst_n      = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // edges of the range, unit boundaries, leap days and century rules
        pending_epochs = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600,
                           32'd86399, 32'd86400, 32'd68169600, 32'd94608000,
                           32'd946684799, 32'd951782400, 32'd951868800,
                           32'd978220800, 32'h7FFF_FFFF, 32'h8000_0000,
                           32'd4107542399, 32'd4107542400, 32'd4133894400,
                           32'd4291747200, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                           32'h5555_5555, 32'hAAAA_AAAA};

        for (int unsigned ph = 0; ph < NumPhases; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 71; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 71; end
                default: begin send_idle_pct = 11; stall_pct = 11; end
            endcase
            for (int unsigned n = 0; n < PhaseItems; n++)
                pending_epochs.push_back(random_epoch());
            while (pending_epochs.size() > 0 || req_ch.valid || expected_dates.size() > 0)
                @(posedge i_clk);
        end

        repeat (DrainCycles) @(posedge i_clk);
        if (expected_dates.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", expected_dates.size()));

        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/ecal_pkg.sv
design/ecal_chan.sv
design/epoch_seconds_to_calendar.sv
tb/tb.sv
